// ===== rtl/utf8_window_decoder_macros.svh =====
// Assertion macros for the UTF-8 window decoder checker.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef UTF8_WINDOW_DECODER_MACROS_SVH
`define UTF8_WINDOW_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define U8WD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define U8WD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/u8wd_pkg.sv =====
// Shared types and constants for the UTF-8 window decoder.
// No dependencies; used by the lead, lane, merge and top-level RTL files.
package u8wd_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned UsedW = 3;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLow     = 21'h00D800;
  localparam logic [CpW-1:0] SurrHigh    = 21'h00DFFF;
  localparam logic [CpW-1:0] Least2      = 21'h000080;
  localparam logic [CpW-1:0] Least3      = 21'h000800;
  localparam logic [CpW-1:0] Least4      = 21'h010000;
  localparam logic [UsedW-1:0] MaxAvail  = 3'd4;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  // Result of classifying the lead byte
  typedef struct packed {
    lead_class_t      cls;
    logic [UsedW-1:0] seq_len;
    logic [CpW-1:0]   least;
  } lead_info_t;

  // Result of one continuation lane
  typedef struct packed {
    logic       is_cont;
    logic [5:0] bits;
  } lane_info_t;

endpackage

// ===== rtl/u8wd_lead.sv =====
// Lead byte classifier for the UTF-8 window decoder.
// Depends on u8wd_pkg.
module u8wd_lead (
  input  logic [7:0]          lead_byte,
  output u8wd_pkg::lead_info_t info
);

  // Decode the lead byte into its sequence class
  always_comb begin
    info.cls     = u8wd_pkg::LEAD_BAD;
    info.seq_len = 3'd1;
    info.least   = '0;
    unique case (lead_byte) inside
      [8'h00:8'h7F]: begin
        info.cls = u8wd_pkg::LEAD_ASCII;
      end
      [8'hC2:8'hDF]: begin
        info.cls     = u8wd_pkg::LEAD_TWO;
        info.seq_len = 3'd2;
        info.least   = u8wd_pkg::Least2;
      end
      [8'hE0:8'hEF]: begin
        info.cls     = u8wd_pkg::LEAD_THREE;
        info.seq_len = 3'd3;
        info.least   = u8wd_pkg::Least3;
      end
      [8'hF0:8'hF4]: begin
        info.cls     = u8wd_pkg::LEAD_FOUR;
        info.seq_len = 3'd4;
        info.least   = u8wd_pkg::Least4;
      end
      default: begin
        info.cls = u8wd_pkg::LEAD_BAD;
      end
    endcase
  end

endmodule

// ===== rtl/u8wd_lane.sv =====
// One continuation lane: checks a trailing byte and strips its tag bits.
// Depends on u8wd_pkg.
module u8wd_lane (
  input  logic [7:0]           lane_byte,
  output u8wd_pkg::lane_info_t info
);

  // Flag a 10xxxxxx byte and pass its six payload bits
  assign info.is_cont = (lane_byte[7:6] == 2'b10);
  assign info.bits    = lane_byte[5:0];

endmodule

// ===== rtl/u8wd_merge.sv =====
// Merge stage: combines lead class and lane results into one code point.
// Depends on u8wd_pkg.
module u8wd_merge (
  input  logic [7:0]                 lead_byte,
  input  logic [2:0]                 bytes_available,
  input  u8wd_pkg::lead_info_t       lead,
  input  u8wd_pkg::lane_info_t [2:0] lanes,
  output logic [20:0]                code_point,
  output logic [2:0]                 bytes_used
);

  logic [2:0]  avail;
  logic        bad_cont;
  logic [20:0] acc;

  // Clamp the available count to the window size
  assign avail = (bytes_available > u8wd_pkg::MaxAvail) ? u8wd_pkg::MaxAvail
                                                        : bytes_available;

  // Look for a broken continuation within the sequence
  assign bad_cont = !lanes[0].is_cont ||
                    ((lead.seq_len >= 3'd3) && !lanes[1].is_cont) ||
                    ((lead.seq_len == 3'd4) && !lanes[2].is_cont);

  // Assemble the scalar for the sequence length
  always_comb begin
    case (lead.cls)
      u8wd_pkg::LEAD_TWO:   acc = {10'd0, lead_byte[4:0], lanes[0].bits};
      u8wd_pkg::LEAD_THREE: acc = {5'd0, lead_byte[3:0], lanes[0].bits, lanes[1].bits};
      u8wd_pkg::LEAD_FOUR:  acc = {lead_byte[2:0], lanes[0].bits, lanes[1].bits,
                                   lanes[2].bits};
      default:              acc = {13'd0, lead_byte};
    endcase
  end

  // Pick the result
  always_comb begin
    code_point = '0;
    bytes_used = '0;
    if (avail != 3'd0) begin
      case (lead.cls)
        u8wd_pkg::LEAD_ASCII: begin
          code_point = {13'd0, lead_byte};
          bytes_used = 3'd1;
        end
        u8wd_pkg::LEAD_BAD: begin
          code_point = u8wd_pkg::Replacement;
          bytes_used = 3'd1;
        end
        default: begin
          if (lead.seq_len <= avail) begin
            if (bad_cont) begin
              code_point = u8wd_pkg::Replacement;
              bytes_used = 3'd1;
            end else begin
              bytes_used = lead.seq_len;
              if ((acc < lead.least) || (acc > u8wd_pkg::MaxScalar) ||
                  ((acc >= u8wd_pkg::SurrLow) && (acc <= u8wd_pkg::SurrHigh))) begin
                code_point = u8wd_pkg::Replacement;
              end else begin
                code_point = acc;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/utf8_window_decoder.sv =====
// Top level of the UTF-8 window decoder: lead classifier, three
// continuation lanes, merge stage and output register. Depends on u8wd_pkg.
//
// Usage:
//   The input channel carries one word per window: four bytes starting at the
//   current buffer position and the count of bytes that exist (0..4, larger
//   values count as 4). The output channel returns one word per window: the
//   decoded code point (U+FFFD on error, 0 when nothing is consumed) and the
//   number of bytes consumed, by which the caller advances its position.
//   A word accepted in one cycle shows on out_valid in the next. Throughput is one
//   word per cycle while the receiver does not stall: the lead classifier and the
//   three lanes work in parallel and the merge stage is combinational ahead of the output register.
//   When the receiver stalls, the output register holds its word and
//   in_stall rises in the same cycle; once the stall drops, the held word
//   leaves and a new one is taken at the same edge.
//   Reset empties the output register; nothing else holds state.
module utf8_window_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_first,
  input  logic [7:0]  in_byte_second,
  input  logic [7:0]  in_byte_third,
  input  logic [7:0]  in_byte_fourth,
  input  logic [2:0]  in_bytes_available,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic [2:0]  out_bytes_used
);

  u8wd_pkg::lead_info_t       lead_info;
  u8wd_pkg::lane_info_t [2:0] lane_info;
  logic [20:0]                cp_nxt;
  logic [2:0]                 used_nxt;
  logic                       valid_r;
  logic                       valid_nxt;
  logic [20:0]                cp_r;
  logic [2:0]                 used_r;
  logic                       take;

  // Classify the lead byte
  u8wd_lead u_lead (
    .lead_byte (in_byte_first),
    .info      (lead_info)
  );

  // Check the trailing bytes side by side
  u8wd_lane u_lane1 (.lane_byte(in_byte_second), .info(lane_info[0]));
  u8wd_lane u_lane2 (.lane_byte(in_byte_third),  .info(lane_info[1]));
  u8wd_lane u_lane3 (.lane_byte(in_byte_fourth), .info(lane_info[2]));

  // Combine lead and lanes
  u8wd_merge u_merge (
    .lead_byte       (in_byte_first),
    .bytes_available (in_bytes_available),
    .lead            (lead_info),
    .lanes           (lane_info),
    .code_point      (cp_nxt),
    .bytes_used      (used_nxt)
  );

  // Stall the input only while a held word cannot leave
  assign in_stall  = valid_r && out_stall;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  // Advance the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cp_r   <= cp_nxt;
      used_r <= used_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_bytes_used = used_r;

endmodule

// ===== rtl/u8wd_checker.sv =====
// Port-level checker for the UTF-8 window decoder, bound to the top level.
// Depends on utf8_window_decoder_macros.svh.
`include "utf8_window_decoder_macros.svh"

module u8wd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] out_code_point,
  input logic [2:0]  out_bytes_used
);

  logic        out_held;
  logic        none_used;
  logic        cp_scalar;
  logic [23:0] out_word;

  // Flag a held output word and a word that consumed nothing
  assign out_held  = out_valid && out_stall;
  assign none_used = out_valid && (out_bytes_used == 3'd0);
  assign out_word  = {out_code_point, out_bytes_used};

  // Flag a code point that is a Unicode scalar value
  assign cp_scalar = (out_code_point <= 21'h10FFFF) &&
                     ((out_code_point < 21'h00D800) || (out_code_point > 21'h00DFFF));

  // Nothing consumed means a zero code point
  `U8WD_ASSERT(a_zero_when_unused, none_used |-> (out_code_point == '0), "nonzero code point")

  // Every word carries a Unicode scalar value
  `U8WD_ASSERT(a_cp_range, out_valid |-> cp_scalar, "code point out of scalar range")

  // Input stalls only behind a held output word
  `U8WD_ASSERT(a_stall_cause, in_stall |-> out_held, "input stalled without a held word")

  // A stalled output word holds
  `U8WD_ASSERT(a_out_hold, out_held |=> (out_valid && $stable(out_word)), "held word changed")

  // Reset empties the output register
  `U8WD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind utf8_window_decoder u8wd_checker u_u8wd_checker (.*);

// ===== verif/tb.sv =====
// Testbench for utf8_window_decoder: directed, random, text-stream and hold-off words
// are checked against a local decode model. Depends on u8wd_pkg and the decoder RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongHold  = 80;

  typedef struct packed {
    logic [u8wd_pkg::CpW-1:0]   code_point;
    logic [u8wd_pkg::UsedW-1:0] bytes_used;
  } decoded_t;

  // Kinds of byte sequence the random generators build
  typedef enum int {
    SEQ_ASCII,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_FOUR,
    SEQ_SURROGATE,
    SEQ_OVERLONG,
    SEQ_ABOVE_MAX,
    SEQ_NOISE
  } seq_kind_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [7:0]                 in_byte_first;
  logic [7:0]                 in_byte_second;
  logic [7:0]                 in_byte_third;
  logic [7:0]                 in_byte_fourth;
  logic [2:0]                 in_bytes_available;
  logic                       out_valid;
  logic                       out_stall;
  logic [u8wd_pkg::CpW-1:0]   out_code_point;
  logic [u8wd_pkg::UsedW-1:0] out_bytes_used;

  decoded_t          pending_points[$];
  int unsigned       mismatch_count = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;
  bit                hold_off_req = 1'b0;
  bit                hold_active = 1'b0;

  utf8_window_decoder u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one window the way the block is meant to
  function automatic decoded_t decode_window(input logic [7:0] b0, b1, b2, b3,
                                             input logic [2:0] avail);
    logic [3:0][7:0]          win;
    u8wd_pkg::lead_class_t    cls;
    logic [u8wd_pkg::CpW-1:0] acc;
    logic [u8wd_pkg::CpW-1:0] least;
    int unsigned              seq_len;
    int unsigned              have;
    decoded_t                 r;
    win = {b3, b2, b1, b0};
    have = 32'((avail > u8wd_pkg::MaxAvail) ? u8wd_pkg::MaxAvail : avail);
    r = '0;
    acc = '0;
    least = '0;
    seq_len = 1;
    // classify the lead
    if (b0 < 8'h80) cls = u8wd_pkg::LEAD_ASCII;
    else if (b0[7:5] == 3'b110 && b0 >= 8'hC2) cls = u8wd_pkg::LEAD_TWO;
    else if (b0[7:4] == 4'b1110) cls = u8wd_pkg::LEAD_THREE;
    else if (b0[7:3] == 5'b11110 && b0 <= 8'hF4) cls = u8wd_pkg::LEAD_FOUR;
    else cls = u8wd_pkg::LEAD_BAD;
    case (cls)
      u8wd_pkg::LEAD_TWO: begin
        acc = u8wd_pkg::CpW'(b0[4:0]);
        seq_len = 2;
        least = u8wd_pkg::Least2;
      end
      u8wd_pkg::LEAD_THREE: begin
        acc = u8wd_pkg::CpW'(b0[3:0]);
        seq_len = 3;
        least = u8wd_pkg::Least3;
      end
      u8wd_pkg::LEAD_FOUR: begin
        acc = u8wd_pkg::CpW'(b0[2:0]);
        seq_len = 4;
        least = u8wd_pkg::Least4;
      end
      default: ;
    endcase
    if (have == 0) return r;
    if (cls == u8wd_pkg::LEAD_ASCII) begin
      r.code_point = u8wd_pkg::CpW'(b0);
      r.bytes_used = 3'd1;
      return r;
    end
    if (cls == u8wd_pkg::LEAD_BAD) begin
      r.code_point = u8wd_pkg::Replacement;
      r.bytes_used = 3'd1;
      return r;
    end
    // truncated: consume nothing
    if (seq_len > have) return r;
    for (int k = 1; k < seq_len; k++) begin
      if (win[k][7:6] != 2'b10) begin
        r.code_point = u8wd_pkg::Replacement;
        r.bytes_used = 3'd1;
        return r;
      end
      acc = (acc << 6) | u8wd_pkg::CpW'(win[k][5:0]);
    end
    if (acc < least || acc > u8wd_pkg::MaxScalar ||
        (acc >= u8wd_pkg::SurrLow && acc <= u8wd_pkg::SurrHigh))
      r.code_point = u8wd_pkg::Replacement;
    else
      r.code_point = acc;
    r.bytes_used = u8wd_pkg::UsedW'(seq_len);
    return r;
  endfunction

  // Encode a scalar in exactly len bytes, overlong or not
  function automatic void encode_as(input logic [20:0] cp, input int unsigned len,
                                    output logic [3:0][7:0] seq);
    seq = '0;
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
  endfunction

  // Build one random sequence, mostly well formed
  function automatic void pick_sequence(output logic [3:0][7:0] seq,
                                        output int unsigned len);
    seq_kind_t   kind;
    logic [20:0] cp;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) kind = SEQ_ASCII;
    else if (roll < 30) kind = SEQ_TWO;
    else if (roll < 48) kind = SEQ_THREE;
    else if (roll < 63) kind = SEQ_FOUR;
    else if (roll < 68) kind = SEQ_SURROGATE;
    else if (roll < 78) kind = SEQ_OVERLONG;
    else if (roll < 84) kind = SEQ_ABOVE_MAX;
    else kind = SEQ_NOISE;
    cp = '0;
    len = 1;
    case (kind)
      SEQ_ASCII: cp = 21'($urandom_range(127));
      SEQ_TWO: begin
        cp = 21'($urandom_range(32'h7FF, 32'h80));
        len = 2;
      end
      SEQ_THREE: begin
        cp = 21'($urandom_range(32'hFFFF, 32'h800));
        len = 3;
      end
      SEQ_FOUR: begin
        cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
        len = 4;
      end
      SEQ_SURROGATE: begin
        cp = 21'($urandom_range(32'hDFFF, 32'hD800));
        len = 3;
      end
      SEQ_OVERLONG: begin
        len = $urandom_range(4, 2);
        cp = 21'($urandom_range((len == 2) ? 32'h7F : (len == 3) ? 32'h7FF : 32'hFFFF));
      end
      SEQ_ABOVE_MAX: begin
        len = 4;
        if ($urandom_range(3) != 0) cp = 21'($urandom_range(32'h13FFFF, 32'h110000));
        else cp = 21'($urandom_range(32'h1FFFFF, 32'h110000));
      end
      default: ;
    endcase
    if (kind == SEQ_NOISE) begin
      seq = $urandom;
      len = $urandom_range(4, 1);
    end else begin
      encode_as(cp, len, seq);
    end
  endfunction

  // Offer one word, hold it until taken, then log the expected result
  task automatic send_word(input logic [7:0] b0, b1, b2, b3, input logic [2:0] avail);
    in_valid           <= 1'b1;
    in_byte_first      <= b0;
    in_byte_second     <= b1;
    in_byte_third      <= b2;
    in_byte_fourth     <= b3;
    in_bytes_available <= avail;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_points.push_back(decode_window(b0, b1, b2, b3, avail));
    // end of burst: maybe insert a gap, then pick the next burst length
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 1);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
  endtask

  // Pause the sender until every outstanding result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // past end, ASCII bounds, stray continuations, bad leads
    send_word(8'h41, 8'h42, 8'h43, 8'h44, 3'd0);
    send_word(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1);
    send_word(8'h7F, 8'h00, 8'h00, 8'h00, 3'd4);
    send_word(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
    send_word(8'hBF, 8'h41, 8'h41, 8'h41, 3'd2);
    send_word(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2);
    send_word(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd2);
    send_word(8'hF5, 8'h80, 8'h80, 8'h80, 3'd4);
    send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
    // shortest and longest of each length
    send_word(8'hC2, 8'h80, 8'hFF, 8'hFF, 3'd2);
    send_word(8'hDF, 8'hBF, 8'h00, 8'h00, 3'd3);
    send_word(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
    send_word(8'hEF, 8'hBF, 8'hBF, 8'h00, 3'd4);
    send_word(8'hEF, 8'hBF, 8'hBD, 8'h00, 3'd3);
    send_word(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4);
    send_word(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4);
    // overlong, surrogate, above the scalar range
    send_word(8'hE0, 8'h80, 8'h80, 8'h00, 3'd3);
    send_word(8'hF0, 8'h80, 8'h80, 8'h80, 3'd4);
    send_word(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
    send_word(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);
    // truncated windows consume nothing
    send_word(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2);
    send_word(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3);
    // bad continuation in second and third place
    send_word(8'hE2, 8'h41, 8'h80, 8'h00, 3'd3);
    send_word(8'hF0, 8'h90, 8'h41, 8'h80, 3'd4);
    // available above four acts as four
    send_word(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd5);
    send_word(8'hE2, 8'h82, 8'hAC, 8'hFF, 3'd6);
  endtask

  task automatic test_random_windows(input int unsigned count);
    logic [3:0][7:0] seq;
    int unsigned     len;
    int unsigned     k;
    int unsigned     pick;
    logic [2:0]      avail;
    repeat (count) begin
      pick_sequence(seq, len);
      // fill bytes past the sequence with anything
      for (k = len; k < 4; k++) seq[k] = 8'($urandom);
      // break one continuation now and then
      if (len > 1 && $urandom_range(99) < 12) begin
        k = $urandom_range(len - 1, 1);
        seq[k] = 8'($urandom);
        while (seq[k][7:6] == 2'b10) seq[k] = 8'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 60) avail = 3'($urandom_range(4, len));
      else if (pick < 72) avail = 3'($urandom_range(7, 5));
      else if (pick < 88) avail = 3'($urandom_range(len - 1, 0));
      else avail = 3'($urandom);
      send_word(seq[0], seq[1], seq[2], seq[3], avail);
    end
  endtask

  // Hold the receiver off while words keep coming so the block fills and stalls
  task automatic test_output_hold();
    logic [3:0][7:0] seq;
    int unsigned     len;
    hold_off_req = 1'b1;
    while (!hold_active) @(posedge clk);
    repeat (40) begin
      pick_sequence(seq, len);
      send_word(seq[0], seq[1], seq[2], seq[3], 3'd4);
    end
  endtask

  // Slide a window over a byte stream, one word per position
  task automatic test_text_stream(input int unsigned min_bytes);
    logic [7:0]      text[$];
    logic [3:0][7:0] seq;
    logic [7:0]      win[4];
    int unsigned     len;
    int unsigned     left;
    while (text.size() < min_bytes) begin
      pick_sequence(seq, len);
      for (int k = 0; k < len; k++) text.push_back(seq[k]);
    end
    for (int pos = 0; pos < text.size(); pos++) begin
      left = text.size() - pos;
      for (int k = 0; k < 4; k++)
        win[k] = (pos + k < text.size()) ? text[pos + k] : 8'($urandom);
      send_word(win[0], win[1], win[2], win[3], 3'((left > 4) ? 4 : left));
    end
  endtask

  // Receiver: random stall stretches, plus one long hold-off on request
  initial begin : receiver
    int unsigned stretch;
    int unsigned pct;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_active = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        stretch = $urandom_range(40, 4);
        case ($urandom_range(3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 60;
          default: pct = 90;
        endcase
        repeat (stretch) begin
          out_stall <= ($urandom_range(99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  // Compare each delivered word with the oldest expectation
  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected word code_point %h bytes_used %0d",
                 $time, out_code_point, out_bytes_used);
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_code_point !== want.code_point) begin
          $display("%0t: code_point expected %h got %h",
                   $time, want.code_point, out_code_point);
          mismatch_count++;
        end
        if (out_bytes_used !== want.bytes_used) begin
          $display("%0t: bytes_used expected %0d got %0d",
                   $time, want.bytes_used, out_bytes_used);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_byte_first      <= 8'h00;
    in_byte_second     <= 8'h00;
    in_byte_third      <= 8'h00;
    in_byte_fourth     <= 8'h00;
    in_bytes_available <= 3'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_for_results();
    test_random_windows(1150);
    wait_for_results();
    test_output_hold();
    wait_for_results();
    test_text_stream(500);
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
